@@ rtl/trapezoidal_speed_profile_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoidal speed profile core
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_SPEED_PROFILE_CORE_MACROS_SVH
`define TRAPEZOIDAL_SPEED_PROFILE_CORE_MACROS_SVH

// Same-cycle implication
`define TSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsp assertion failed");

// Next-cycle implication
`define TSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsp assertion failed");

`endif

@@ rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the trapezoidal speed profile core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int TSP_SPEED_WIDTH_DEF = 16;
  localparam int TSP_TICK_WIDTH_DEF  = 32;

  localparam int TSP_FIELD_W = 16;
  localparam int TSP_DIST_W  = 16;
  localparam int TSP_CFG_W   = 24;
  localparam int TSP_PROD_W  = TSP_DIST_W + TSP_CFG_W + 1;

  localparam logic [TSP_CFG_W-1:0] TSP_CFG_RESET = 24'd1000;
  localparam int TSP_RAMP_DEN = 5;

  localparam int TSP_MD_A_W_DEF = 41;
  localparam int TSP_MD_C_W_DEF = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_TOGGLE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACC    = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DEC    = 2'd3
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

endpackage

@@ rtl/trapezoidal_speed_profile_core.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_speed_profile_core
// Trapezoidal speed profile for one straight move, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Input stream s_*: one command per transfer, op in s_tuser (tick, start,
// pause toggle), distance and speeds in s_tdata. Every command yields exactly
// one result transfer on m_*: speed, drive_on and phase in m_tdata, done in
// m_tlast. cfg_* writes ticks_per_distance; write it only while idle.
// One command is worked on at a time; s_tready is high only when idle.
// Tick or toggle in a ramp phase: the result comes from the shared bit-serial
// multiply-divide, which takes a double step and an add step per bit of the
// speed difference; a cruise tick or an idle tick does not use it.
// Start: serial multiply over the DIST_W distance bits, the move length
// division over 41 bits, the ramp length division over TICK_WIDTH+1 bits,
// then one report.
// The result sits in an output register; when the receiver stalls the
// block holds it and waits with the next result before taking more input.
// Reset clears the move, the pause flag and loads ticks_per_distance = 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trapezoidal_speed_profile_core_macros.svh"

module trapezoidal_speed_profile_core import tsp_pkg::*; #(
  parameter int SPEED_WIDTH = TSP_SPEED_WIDTH_DEF,
  parameter int TICK_WIDTH  = TSP_TICK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // distance[15:0], start_speed[31:16], peak_speed[47:32]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // speed[15:0], drive_on[16], phase[18:17], zero[23:19]
  output logic        m_tlast,   // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data   // ticks_per_distance[23:0]
);

  localparam int SW     = SPEED_WIDTH;
  localparam int TW     = TICK_WIDTH;
  localparam int SX     = (SW > TSP_FIELD_W) ? SW : TSP_FIELD_W;
  localparam int AW0    = (TSP_PROD_W > TW + 1) ? TSP_PROD_W : TW + 1;
  localparam int AW     = (AW0 > SW) ? AW0 : SW;
  localparam int CW     = (SW + 1 > TW) ? SW + 1 : TW;
  localparam int LEN_W  = $clog2(AW + 1);
  localparam int MCNT_W = $clog2(TSP_DIST_W + 1);
  localparam int SH_TOT = AW - TSP_PROD_W;
  localparam int SH_RMP = AW - (TW + 1);
  localparam int SH_SPD = AW - SW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_RAMP_GO,
    ST_RAMP,
    ST_CEND,
    ST_TICK_CHK,
    ST_PHASE,
    ST_MD,
    ST_OUT
  } state_t;

  state_t                  state;
  logic [TSP_CFG_W-1:0]    ticks_per_distance;
  logic [TW-1:0]           tick_count;
  logic [TW-1:0]           total_ticks;
  logic [TW-1:0]           ramp_ticks;
  logic [TW-1:0]           cruise_end;
  logic [SW-1:0]           start_speed_held;
  logic [SW-1:0]           peak_speed_held;
  logic [SW-1:0]           speed_diff;
  logic                    ramp_up;
  logic [SW:0]             speed_sum;
  logic                    move_active;
  logic                    paused;
  logic [TSP_DIST_W-1:0]   dist_sh;
  logic [MCNT_W-1:0]       mcnt;
  logic [TSP_PROD_W-1:0]   prod;
  logic [SW-1:0]           res_speed;
  logic                    res_drive;
  phase_t                  res_phase;
  logic                    res_done;

  logic                    md_go;
  logic [AW-1:0]           md_a;
  logic [LEN_W-1:0]        md_len;
  logic [CW-1:0]           md_b;
  logic [CW-1:0]           md_c;
  logic [AW-1:0]           md_q;
  md_status_t              md_stat;

  op_t                     in_op;
  logic [SW-1:0]           in_start;
  logic [SW-1:0]           in_peak;
  logic [TSP_CFG_W:0]      tpd2;
  logic [SW-1:0]           md_off;
  logic [SX-1:0]           speed_x;

  assign in_op     = op_t'(s_tuser);
  assign in_start  = SW'(SX'(s_tdata[31:16]));
  assign in_peak   = SW'(SX'(s_tdata[47:32]));
  assign tpd2      = {ticks_per_distance, 1'b0};
  assign md_off    = md_q[SW-1:0];
  assign speed_x   = SX'(res_speed);
  assign s_tready  = state == ST_IDLE;
  assign cfg_ready = 1'b1;

  tsp_muldiv #(
    .A_W (AW),
    .C_W (CW)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_go),
    .a     (md_a),
    .len   (md_len),
    .b     (md_b),
    .c     (md_c),
    .q     (md_q),
    .stat  (md_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      ticks_per_distance <= TSP_CFG_RESET;
      tick_count         <= '0;
      total_ticks        <= '0;
      ramp_ticks         <= '0;
      cruise_end         <= '0;
      start_speed_held   <= '0;
      peak_speed_held    <= '0;
      move_active        <= 1'b0;
      paused             <= 1'b0;
      md_go              <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      md_go <= 1'b0;
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        ticks_per_distance <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (in_op)
              OP_START: begin
                start_speed_held <= in_start;
                peak_speed_held  <= in_peak;
                paused           <= 1'b0;
                tick_count       <= '0;
                dist_sh          <= s_tdata[15:0];
                prod             <= '0;
                mcnt             <= MCNT_W'(TSP_DIST_W);
                state            <= ST_START;
              end
              OP_TOGGLE: begin
                paused <= !paused;
                state  <= ST_PHASE;
              end
              OP_TICK: begin
                if (move_active && !paused) begin
                  tick_count <= tick_count + TW'(1);
                  state      <= ST_TICK_CHK;
                end else begin
                  state <= ST_PHASE;
                end
              end
              default: state <= ST_PHASE;
            endcase
          end
        end
        ST_START: begin
          speed_sum <= {1'b0, start_speed_held} + {1'b0, peak_speed_held};
          ramp_up   <= peak_speed_held >= start_speed_held;
          if (peak_speed_held >= start_speed_held) begin
            speed_diff <= peak_speed_held - start_speed_held;
          end else begin
            speed_diff <= start_speed_held - peak_speed_held;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mcnt != '0) begin
            prod    <= {prod[TSP_PROD_W-2:0], 1'b0}
                       + (dist_sh[TSP_DIST_W-1] ? TSP_PROD_W'(tpd2) : '0);
            dist_sh <= {dist_sh[TSP_DIST_W-2:0], 1'b0};
            mcnt    <= mcnt - MCNT_W'(1);
          end else if (speed_sum == '0) begin
            total_ticks <= '0;
            ramp_ticks  <= '0;
            move_active <= 1'b0;
            res_speed   <= '0;
            res_drive   <= 1'b0;
            res_phase   <= PH_IDLE;
            res_done    <= 1'b1;
            state       <= ST_OUT;
          end else begin
            md_go  <= 1'b1;
            md_a   <= AW'(prod) << SH_TOT;
            md_len <= LEN_W'(TSP_PROD_W);
            md_b   <= CW'(1);
            md_c   <= CW'(speed_sum);
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (md_stat.done) begin
            if (|md_q[AW-1:TW]) begin
              total_ticks <= '1;
            end else begin
              total_ticks <= md_q[TW-1:0];
            end
            state <= ST_RAMP_GO;
          end
        end
        ST_RAMP_GO: begin
          if (total_ticks == '0) begin
            ramp_ticks  <= '0;
            move_active <= 1'b0;
            res_speed   <= '0;
            res_drive   <= 1'b0;
            res_phase   <= PH_IDLE;
            res_done    <= 1'b1;
            state       <= ST_OUT;
          end else begin
            md_go  <= 1'b1;
            md_a   <= AW'({total_ticks, 1'b0}) << SH_RMP;
            md_len <= LEN_W'(TW + 1);
            md_b   <= CW'(1);
            md_c   <= CW'(TSP_RAMP_DEN);
            state  <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (md_stat.done) begin
            ramp_ticks <= md_q[TW-1:0];
            state      <= ST_CEND;
          end
        end
        ST_CEND: begin
          cruise_end  <= total_ticks - ramp_ticks;
          move_active <= 1'b1;
          state       <= ST_PHASE;
        end
        ST_TICK_CHK: begin
          if (tick_count >= total_ticks) begin
            move_active <= 1'b0;
            tick_count  <= '0;
            res_speed   <= '0;
            res_drive   <= 1'b0;
            res_phase   <= PH_IDLE;
            res_done    <= 1'b1;
            state       <= ST_OUT;
          end else begin
            state <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          res_done <= 1'b0;
          if (!move_active) begin
            res_speed <= '0;
            res_drive <= 1'b0;
            res_phase <= PH_IDLE;
            state     <= ST_OUT;
          end else begin
            res_drive <= !paused;
            md_a      <= AW'(speed_diff) << SH_SPD;
            md_len    <= LEN_W'(SW);
            md_c      <= CW'(ramp_ticks);
            if (tick_count < ramp_ticks) begin
              res_phase <= PH_ACC;
              md_b      <= CW'(tick_count);
              md_go     <= 1'b1;
              state     <= ST_MD;
            end else if (tick_count < cruise_end) begin
              res_phase <= PH_CRUISE;
              res_speed <= peak_speed_held;
              state     <= ST_OUT;
            end else begin
              res_phase <= PH_DEC;
              md_b      <= CW'(tick_count - cruise_end);
              md_go     <= 1'b1;
              state     <= ST_MD;
            end
          end
        end
        ST_MD: begin
          if (md_stat.done) begin
            if (res_phase == PH_ACC) begin
              res_speed <= ramp_up ? start_speed_held + md_off
                                   : start_speed_held - md_off;
            end else begin
              res_speed <= ramp_up ? peak_speed_held - md_off
                                   : peak_speed_held + md_off;
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, res_phase, res_drive, speed_x[TSP_FIELD_W-1:0]};
            m_tlast  <= res_done;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TSP_ASSERT_IMP(a_idle_md_free, s_tready, !md_stat.busy)
  `TSP_ASSERT_IMP(a_count_in_move, s_tready && move_active, tick_count < total_ticks)
  `TSP_ASSERT_IMP(a_done_is_idle, m_tvalid && m_tlast,
                  !m_tdata[16] && (m_tdata[18:17] == PH_IDLE))
  `TSP_ASSERT_IMP(a_drive_has_phase, m_tvalid && m_tdata[16], m_tdata[18:17] != PH_IDLE)

endmodule

@@ rtl/tsp_muldiv.sv @@
// ----------------------------------------------------------------------------
// tsp_muldiv
// Bit-serial floor(a * b / c) for b < c. The multiplier a enters MSB first,
// left-aligned, len bits; each bit takes a double step and an add step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_muldiv import tsp_pkg::*; #(
  parameter int A_W = TSP_MD_A_W_DEF,
  parameter int C_W = TSP_MD_C_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [A_W-1:0]             a,
  input  logic [$clog2(A_W+1)-1:0]   len,
  input  logic [C_W-1:0]             b,
  input  logic [C_W-1:0]             c,
  output logic [A_W-1:0]             q,
  output md_status_t                 stat
);

  localparam int LEN_W = $clog2(A_W + 1);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_DBL,
    MD_ADD
  } md_state_t;

  md_state_t        state;
  logic [A_W-1:0]   a_sh;
  logic [LEN_W-1:0] cnt;
  logic [C_W:0]     r;
  logic [C_W-1:0]   b_r;
  logic [C_W-1:0]   c_r;
  logic             done;

  logic [C_W:0] r_dbl;
  logic [C_W:0] r_add;
  logic [C_W:0] c_ext;
  logic         dbl_ge;
  logic         add_ge;

  assign c_ext  = {1'b0, c_r};
  assign r_dbl  = {r[C_W-1:0], 1'b0};
  assign r_add  = r + {1'b0, b_r};
  assign dbl_ge = r_dbl >= c_ext;
  assign add_ge = r_add >= c_ext;

  assign stat.busy = state != MD_IDLE;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            a_sh  <= a;
            cnt   <= len;
            r     <= '0;
            q     <= '0;
            b_r   <= b;
            c_r   <= c;
            state <= MD_DBL;
          end
        end
        MD_DBL: begin
          if (dbl_ge) begin
            r <= r_dbl - c_ext;
            q <= {q[A_W-2:0], 1'b1};
          end else begin
            r <= r_dbl;
            q <= {q[A_W-2:0], 1'b0};
          end
          state <= MD_ADD;
        end
        MD_ADD: begin
          if (a_sh[A_W-1]) begin
            if (add_ge) begin
              r <= r_add - c_ext;
              q <= q + A_W'(1);
            end else begin
              r <= r_add;
            end
          end
          a_sh <= {a_sh[A_W-2:0], 1'b0};
          cnt  <= cnt - LEN_W'(1);
          if (cnt == LEN_W'(1)) begin
            done  <= 1'b1;
            state <= MD_IDLE;
          end else begin
            state <= MD_DBL;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule
